FILE: rtl/atrp_pkg.sv
package atrp_pkg;

  localparam int IN_W     = 16;
  localparam int ROLL_W   = 16;
  localparam int PITCH_W  = 15;

  // y*y + z*z, square root and its partial remainder
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 34;
  localparam int SQRT_STEPS = ROOT_W;

  // cordic operands carry 24 fraction bits, the root carries 16
  localparam int CORDIC_STAGES = 32;
  localparam int OPND_SHIFT    = 24;
  localparam int ROOT_SHIFT    = OPND_SHIFT - 16;
  localparam int DP_W          = 43;
  localparam int ANG_W         = 34;
  localparam int MAG_W         = ANG_W - 1;

  // angle accumulator counts 2^32 per turn
  localparam int TURN_BITS = 32;
  localparam int DEG_W     = 9;
  localparam logic [DEG_W-1:0] DEG_PER_TURN = 9'd360;

  localparam int ANGLE_FRAC_BITS_DEF = 7;

  typedef logic signed [DP_W-1:0]  dp_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t QUARTER_TURN = 34'sh0_4000_0000;

  typedef struct packed {
    dp_t  x;
    dp_t  y;
    ang_t a;
  } cvec_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // left half plane is turned by a quarter turn before the chain
  function automatic cvec_t cordic_fold(dp_t xi, dp_t yi);
    cvec_t v;
    v.x = xi;
    v.y = yi;
    v.a = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        v.x = yi;
        v.y = -xi;
        v.a = QUARTER_TURN;
      end else begin
        v.x = -yi;
        v.y = xi;
        v.a = -QUARTER_TURN;
      end
    end
    return v;
  endfunction

  // one vectoring micro-rotation; a zero residual leaves the vector alone
  function automatic cvec_t cordic_rot(cvec_t v, dp_t xs, dp_t ys, ang_t t);
    cvec_t r;
    r = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.a = v.a + t;
    end else if (v.y < 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.a = v.a - t;
    end
    return r;
  endfunction

endpackage

FILE: rtl/accel_tilt_roll_pitch_top.sv
// Tilt from one three-axis accelerometer sample: roll = atan2(y, z) and
// pitch = atan2(-x, |(y,z)|), both in degrees with ANGLE_FRACTION_BITS
// fraction bits (1/128 degree by default), rounded half away from zero.
// The pipeline takes one sample per clock while sample_stall is low; each sample
// passes through the squaring and sum (2 stages), a
// 32-stage one-bit-per-stage square root, an operand fold, two 32-stage CORDIC
// vectoring chains side by side, and 4 stages of degree scaling and rounding.
// A result held by angle_stall sits in the output register while a second one
// goes to a skid register; sample_stall rises only once the skid is full, and
// then the whole pipeline holds.
module accel_tilt_roll_pitch_top #(
  parameter int ANGLE_FRACTION_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_x,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_y,
  input  logic signed [atrp_pkg::IN_W-1:0]     accel_z,
  output logic                                 angle_valid,
  input  logic                                 angle_stall,
  output logic signed [atrp_pkg::ROLL_W-1:0]   roll_angle,
  output logic signed [atrp_pkg::PITCH_W-1:0]  pitch_angle
);
  import atrp_pkg::*;

  localparam int PROD_W    = MAG_W + DEG_W;
  localparam int SUM_W_MIN = PROD_W + ANGLE_FRACTION_BITS + 1;
  localparam int RND_W     = (SUM_W_MIN > TURN_BITS + ROLL_W) ? SUM_W_MIN : TURN_BITS + ROLL_W;

  logic en;
  logic skid_v;

  // squares
  logic                      v1;
  logic signed [IN_W-1:0]    x1, y1, z1;
  logic [SQ_W-1:0]           yy1, zz1;
  logic signed [2*IN_W-1:0]  yy_p, zz_p;

  // square root
  logic                      sq_v    [0:SQRT_STEPS];
  logic [SQ_W-1:0]           sq_s    [0:SQRT_STEPS-1];
  logic [REM_W-1:0]          sq_rem  [0:SQRT_STEPS-1];
  logic [ROOT_W-1:0]         sq_root [0:SQRT_STEPS];
  logic signed [IN_W-1:0]    sq_x    [0:SQRT_STEPS];
  logic signed [IN_W-1:0]    sq_y    [0:SQRT_STEPS];
  logic signed [IN_W-1:0]    sq_z    [0:SQRT_STEPS];

  // cordic chains, roll and pitch
  logic                      cv [0:CORDIC_STAGES];
  cvec_t                     cr [0:CORDIC_STAGES];
  cvec_t                     cp [0:CORDIC_STAGES];
  dp_t                       roll_xo, roll_yo, pitch_xo, pitch_yo, xo;

  // degree scaling
  logic                      d1_v, d2_v, d3_v, fin_v;
  logic                      d1_neg_r, d1_neg_p, d2_neg_r, d2_neg_p, d3_neg_r, d3_neg_p;
  logic [MAG_W-1:0]          d1_mag_r, d1_mag_p;
  logic [PROD_W-1:0]         d2_prod_r, d2_prod_p;
  logic [ROLL_W-1:0]         d3_r;
  logic [PITCH_W-1:0]        d3_p;
  ang_t                      roll_neg_a, pitch_neg_a;
  logic [RND_W-1:0]          rsum_r, rsum_p;
  logic signed [ROLL_W-1:0]  fin_roll, skid_roll;
  logic signed [PITCH_W-1:0] fin_pitch, skid_pitch;

  assign en           = !skid_v;
  assign sample_stall = skid_v;

  assign yy_p = (2*IN_W)'(accel_y) * (2*IN_W)'(accel_y);
  assign zz_p = (2*IN_W)'(accel_z) * (2*IN_W)'(accel_z);

  always_ff @(posedge clk) begin
    if (en) begin
      x1          <= accel_x;
      y1          <= accel_y;
      z1          <= accel_z;
      yy1         <= unsigned'(yy_p);
      zz1         <= unsigned'(zz_p);
      sq_s[0]     <= yy1 + zz1;
      sq_rem[0]   <= '0;
      sq_root[0]  <= '0;
      sq_x[0]     <= x1;
      sq_y[0]     <= y1;
      sq_z[0]     <= z1;
    end
  end

  // restoring square root of (y*y + z*z) * 2^32, one root bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [REM_W+1:0] trem;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign trem  = {sq_rem[j], sq_s[j][SQ_W-1 -: 2]};
    assign trial = (REM_W+2)'({sq_root[j], 2'b01});
    assign ge    = trem >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root[j+1] <= {sq_root[j][ROOT_W-2:0], ge};
        sq_x[j+1]    <= sq_x[j];
        sq_y[j+1]    <= sq_y[j];
        sq_z[j+1]    <= sq_z[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_rem
      logic [REM_W+1:0] diff;

      assign diff = trem - trial;

      always_ff @(posedge clk) begin
        if (en) begin
          sq_rem[j+1] <= ge ? diff[REM_W-1:0] : trem[REM_W-1:0];
          sq_s[j+1]   <= sq_s[j] << 2;
        end
      end
    end
  end

  // operand scaling and quadrant fold
  assign xo       = dp_t'(sq_x[SQRT_STEPS]);
  assign roll_xo  = dp_t'(sq_z[SQRT_STEPS]) <<< OPND_SHIFT;
  assign roll_yo  = dp_t'(sq_y[SQRT_STEPS]) <<< OPND_SHIFT;
  assign pitch_xo = dp_t'({sq_root[SQRT_STEPS], {ROOT_SHIFT{1'b0}}});
  assign pitch_yo = (-xo) <<< OPND_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= cordic_fold(roll_xo, roll_yo);
      cp[0] <= cordic_fold(pitch_xo, pitch_yo);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ang_t t;

    assign t = ang_t'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        cr[i+1] <= cordic_rot(cr[i], cr[i].x >>> i, cr[i].y >>> i, t);
        cp[i+1] <= cordic_rot(cp[i], cp[i].x >>> i, cp[i].y >>> i, t);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end
  end

  // sign and magnitude, times 360, round at the turn boundary, restore sign
  assign roll_neg_a  = -cr[CORDIC_STAGES].a;
  assign pitch_neg_a = -cp[CORDIC_STAGES].a;

  assign rsum_r = (RND_W'(d2_prod_r) << ANGLE_FRACTION_BITS) + (RND_W'(1) << (TURN_BITS - 1));
  assign rsum_p = (RND_W'(d2_prod_p) << ANGLE_FRACTION_BITS) + (RND_W'(1) << (TURN_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_neg_r  <= cr[CORDIC_STAGES].a[ANG_W-1];
      d1_neg_p  <= cp[CORDIC_STAGES].a[ANG_W-1];
      d1_mag_r  <= cr[CORDIC_STAGES].a[ANG_W-1] ? roll_neg_a[MAG_W-1:0]
                                                 : cr[CORDIC_STAGES].a[MAG_W-1:0];
      d1_mag_p  <= cp[CORDIC_STAGES].a[ANG_W-1] ? pitch_neg_a[MAG_W-1:0]
                                                 : cp[CORDIC_STAGES].a[MAG_W-1:0];
      d2_neg_r  <= d1_neg_r;
      d2_neg_p  <= d1_neg_p;
      d2_prod_r <= PROD_W'(d1_mag_r) * PROD_W'(DEG_PER_TURN);
      d2_prod_p <= PROD_W'(d1_mag_p) * PROD_W'(DEG_PER_TURN);
      d3_neg_r  <= d2_neg_r;
      d3_neg_p  <= d2_neg_p;
      d3_r      <= rsum_r[TURN_BITS +: ROLL_W];
      d3_p      <= rsum_p[TURN_BITS +: PITCH_W];
      fin_roll  <= d3_neg_r ? -d3_r : d3_r;
      fin_pitch <= d3_neg_p ? -d3_p : d3_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      sq_v[0] <= 1'b0;
      cv[0]   <= 1'b0;
      d1_v    <= 1'b0;
      d2_v    <= 1'b0;
      d3_v    <= 1'b0;
      fin_v   <= 1'b0;
    end else if (en) begin
      v1      <= sample_valid;
      sq_v[0] <= v1;
      cv[0]   <= sq_v[SQRT_STEPS];
      d1_v    <= cv[CORDIC_STAGES];
      d2_v    <= d1_v;
      d3_v    <= d2_v;
      fin_v   <= d3_v;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_v      <= 1'b0;
    end else if (!angle_valid || !angle_stall) begin
      if (skid_v) begin
        angle_valid <= 1'b1;
        skid_v      <= 1'b0;
      end else begin
        angle_valid <= fin_v;
      end
    end else if (fin_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!angle_valid || !angle_stall) begin
      if (skid_v) begin
        roll_angle  <= skid_roll;
        pitch_angle <= skid_pitch;
      end else begin
        roll_angle  <= fin_roll;
        pitch_angle <= fin_pitch;
      end
    end else if (fin_v && en) begin
      skid_roll  <= fin_roll;
      skid_pitch <= fin_pitch;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> angle_valid)
    else $error("skid entry held without an output transaction ahead of it");

  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && angle_stall && !skid_v && fin_v) |=> skid_v)
    else $error("finished result dropped while output was stalled");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && !angle_stall && skid_v) |=>
      (angle_valid && roll_angle == $past(skid_roll) && pitch_angle == $past(skid_pitch)))
    else $error("skid entry not delivered next");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_v |=> ($stable(fin_v) && $stable(fin_roll) && $stable(fin_pitch)))
    else $error("pipeline moved while skid was full");
`endif

endmodule

FILE: dv/tb_accel_tilt_roll_pitch_top.sv
`timescale 1ns / 1ps

module tb_accel_tilt_roll_pitch_top;
  import atrp_pkg::*;

  localparam int ANGLE_FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int TILT_STAGES = 32;
  localparam longint TILT_QTURN = 64'sh4000_0000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [31:0] ARCTAN_STEP [TILT_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } accel_sample_t;

  typedef struct {
    logic [ROLL_W-1:0]  roll;
    logic [PITCH_W-1:0] pitch;
  } tilt_angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [IN_W-1:0] accel_x = '0;
  logic signed [IN_W-1:0] accel_y = '0;
  logic signed [IN_W-1:0] accel_z = '0;
  logic angle_valid;
  logic angle_stall = 1'b0;
  logic signed [ROLL_W-1:0] roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;

  accel_sample_t sample_q[$];
  tilt_angles_t angles_q[$];
  logic sample_taken = 1'b0;
  int send_idle_pct = 33;
  int recv_idle_pct = 72;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fail_count = 0;

  accel_tilt_roll_pitch_top #(
    .ANGLE_FRACTION_BITS(ANGLE_FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .accel_z(accel_z),
    .angle_valid(angle_valid),
    .angle_stall(angle_stall),
    .roll_angle(roll_angle),
    .pitch_angle(pitch_angle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // vectoring cordic, 2^32 angle units per turn
  function automatic longint vector_angle(longint num, longint den);
    longint ang;
    longint xs;
    longint ys;
    longint t;
    ang = 0;
    if (num == 0 && den == 0) return 0;
    if (den < 0) begin
      t = den;
      if (num >= 0) begin
        den = num;
        num = -t;
        ang = TILT_QTURN;
      end else begin
        den = -num;
        num = t;
        ang = -TILT_QTURN;
      end
    end
    for (int i = 0; i < TILT_STAGES; i++) begin
      xs = den >>> i;
      ys = num >>> i;
      if (num > 0) begin
        den = den + ys;
        num = num - xs;
        ang = ang + longint'(ARCTAN_STEP[i]);
      end else if (num < 0) begin
        den = den - ys;
        num = num + xs;
        ang = ang - longint'(ARCTAN_STEP[i]);
      end
    end
    return ang;
  endfunction

  // half away from zero
  function automatic logic [63:0] turns_to_degrees(longint ang);
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    mag = (ang < 0) ? -ang : ang;
    prod = (mag * 64'd360) << ANGLE_FRAC;
    r = (prod + 64'h8000_0000) >> 32;
    return (ang < 0) ? -r : r;
  endfunction

  function automatic tilt_angles_t predict_tilt(accel_sample_t s);
    longint x;
    longint y;
    longint z;
    longint mag_yz;
    logic [63:0] sq;
    logic [63:0] roll_deg;
    logic [63:0] pitch_deg;
    tilt_angles_t e;
    x = longint'(s.x);
    y = longint'(s.y);
    z = longint'(s.z);
    sq = 64'(y * y + z * z) << 32;
    mag_yz = longint'(floor_sqrt(sq));
    roll_deg = turns_to_degrees(vector_angle(y <<< 24, z <<< 24));
    pitch_deg = turns_to_degrees(vector_angle((-x) <<< 24, mag_yz <<< 8));
    e.roll = roll_deg[ROLL_W-1:0];
    e.pitch = pitch_deg[PITCH_W-1:0];
    return e;
  endfunction

  function automatic logic signed [IN_W-1:0] rand_axis();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2, 3: return IN_W'(int'($urandom_range(16)) - 8);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic queue_sample(int x, int y, int z);
    accel_sample_t s;
    s.x = IN_W'(x);
    s.y = IN_W'(y);
    s.z = IN_W'(z);
    sample_q.push_back(s);
  endtask

  task automatic queue_random(int count);
    accel_sample_t s;
    repeat (count) begin
      s.x = rand_axis();
      s.y = rand_axis();
      s.z = rand_axis();
      sample_q.push_back(s);
    end
  endtask

  task automatic wait_all_done();
    while (sample_q.size() != 0 || sample_valid || angles_q.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin : sample_driver
    accel_sample_t s;
    if (!rst && (!sample_valid || sample_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = sample_q.pop_front();
        sample_valid <= 1'b1;
        accel_x <= s.x;
        accel_y <= s.y;
        accel_z <= s.z;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      angle_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      angle_stall <= 1'b1;
    end else begin
      angle_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : angle_monitor
    tilt_angles_t e;
    accel_sample_t s;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      // check before queueing so a result can never match its own transaction
      if (angle_valid && !angle_stall) begin
        if (angles_q.size() == 0) begin
          $error("unexpected result roll_angle=%0d pitch_angle=%0d", roll_angle, pitch_angle);
          fail_count++;
        end else begin
          e = angles_q.pop_front();
          if (roll_angle !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", $signed(e.roll), roll_angle);
            fail_count++;
          end
          if (pitch_angle !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", $signed(e.pitch), pitch_angle);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        s.x = accel_x;
        s.y = accel_y;
        s.z = accel_z;
        angles_q.push_back(predict_tilt(s));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners: origin, axis-only vectors, extremes, near +-180 roll
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 1);
    queue_sample(0, 0, -1);
    queue_sample(0, 0, -32768);
    queue_sample(0, 0, 32767);
    queue_sample(1, 0, 0);
    queue_sample(-1, 0, 0);
    queue_sample(32767, 0, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 32767, 0);
    queue_sample(0, -32768, 0);
    queue_sample(0, -1, -32768);
    queue_sample(0, 1, -32768);
    queue_sample(0, -32768, -32768);
    queue_sample(0, 32767, 32767);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(32767, -32768, 32767);
    queue_sample(-32768, 32767, -32768);
    queue_sample(-32768, 1, 0);
    queue_sample(12345, -23456, 3456);
    queue_sample(-1, -1, -1);
    wait_all_done();

    // output held off while the sender keeps going, so input backs up
    hold_requests++;
    queue_random(200);
    wait_all_done();
    queue_random(380);
    wait_all_done();

    send_idle_pct = 72;
    recv_idle_pct = 33;
    queue_random(580);
    wait_all_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(590);
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/atrp_pkg.sv
rtl/accel_tilt_roll_pitch_top.sv
dv/tb_accel_tilt_roll_pitch_top.sv
